FILE: src/pqs_pkg.sv
// Shared types and codes for the periodic query scheduler.
// Used by pqs_cell and periodic_query_scheduler; depends on nothing else.
package pqs_pkg;

  localparam int TimeW   = 32;
  localparam int IdW     = 16;
  localparam int PeriodW = 16;

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_POP      = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  typedef struct packed {
    logic [TimeW-1:0]   fire_time;
    logic [IdW-1:0]     id;
    logic [PeriodW-1:0] period;
  } entry_t;

  // Commands broadcast from the controller to every cell.
  typedef struct packed {
    logic ins;  // insert the broadcast entry at its sorted place
    logic shl;  // drop the head, every cell takes its right neighbor
  } cell_ctrl_t;

endpackage

FILE: src/pqs_cell.sv
// One cell of the sorted entry chain of the periodic query scheduler.
// Depends on pqs_pkg for the entry and command types.
module pqs_cell #(
  parameter int SLOTW = 6
) (
  input  logic                clk,
  input  pqs_pkg::cell_ctrl_t ctrl,
  input  logic                valid,
  input  pqs_pkg::entry_t     new_entry,
  input  logic [SLOTW-1:0]    new_slot,
  input  logic                left_lt,
  input  pqs_pkg::entry_t     left_entry,
  input  logic [SLOTW-1:0]    left_slot,
  input  pqs_pkg::entry_t     right_entry,
  input  logic [SLOTW-1:0]    right_slot,
  output logic                new_lt,
  output pqs_pkg::entry_t     entry,
  output logic [SLOTW-1:0]    slot
);
  import pqs_pkg::*;

  entry_t           entry_r, entry_nxt;
  logic [SLOTW-1:0] slot_r, slot_nxt;

  // The order key is firing time, then id, then table slot; an empty cell
  // sorts after everything.
  assign new_lt = !valid ||
                  ({new_entry.fire_time, new_entry.id, new_slot} <
                   {entry_r.fire_time, entry_r.id, slot_r});

  always_comb begin
    entry_nxt = entry_r;
    slot_nxt  = slot_r;
    if (ctrl.shl) begin
      entry_nxt = right_entry;
      slot_nxt  = right_slot;
    end else if (ctrl.ins) begin
      if (left_lt) begin
        entry_nxt = left_entry;
        slot_nxt  = left_slot;
      end else if (new_lt) begin
        entry_nxt = new_entry;
        slot_nxt  = new_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    slot_r  <= slot_nxt;
  end

  assign entry = entry_r;
  assign slot  = slot_r;

endmodule

FILE: src/periodic_query_scheduler.sv
// Top level of the periodic query scheduler: controller and chain of cells.
// Depends on pqs_pkg and pqs_cell.
//
// A request is taken at a rising edge where start is high and busy is low.
// in_operation selects register (store in_query_id with in_period, first
// firing at in_period) or pop (return the entry with the smallest firing
// time, ties to the smaller id, then to the earlier registration).
// Each request gives exactly one result, shown for one cycle with out_valid
// high in the cycle after the request was taken; the receiver cannot stall.
// The entries sit sorted in a chain of MAX_ENTRIES cells, so the head is
// always the next to fire. A register request is inserted at the edge that takes it, and
// the block can take a new request every cycle that busy is low. A pop shifts the chain toward the
// head and then reinserts the rescheduled entry in the next cycle, so busy
// is high for one cycle, and no new request is taken while busy is high.
// A firing time that would pass 32 bits saturates and reports status 3.
// Reset empties the table; no clearing pass is needed.
module periodic_query_scheduler #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [15:0] in_query_id,
  input  logic [15:0] in_period,
  output logic        out_valid,
  output logic [15:0] out_fired_id,
  output logic [31:0] out_fire_time,
  output logic [1:0]  out_status
);
  import pqs_pkg::*;

  localparam int SLOTW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNTW  = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNTW-1:0] MaxCnt = CNTW'(MAX_ENTRIES);

  logic [CNTW-1:0]  count_r, count_nxt;
  logic             busy_r, busy_nxt;
  entry_t           pend_r, pend_nxt;
  logic [SLOTW-1:0] pend_slot_r, pend_slot_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      out_id_r, out_id_nxt;
  logic [31:0]      out_time_r, out_time_nxt;
  logic [1:0]       out_status_r, out_status_nxt;

  logic             accept;
  logic             is_full, is_empty;
  logic [CNTW-1:0]  occupancy;
  logic [TimeW:0]   next_sum;
  cell_ctrl_t       ctrl;
  entry_t           new_entry;
  logic [SLOTW-1:0] new_slot;

  entry_t           cell_e [MAX_ENTRIES];
  logic [SLOTW-1:0] cell_s [MAX_ENTRIES];
  logic             cell_lt [MAX_ENTRIES];

  assign accept   = start && !busy_r;
  assign is_full  = (count_r == MaxCnt);
  assign is_empty = (count_r == '0);
  assign busy     = busy_r;

  // During the reinsert cycle the head has already left the chain.
  assign occupancy = busy_r ? (count_r - CNTW'(1)) : count_r;
  assign next_sum  = {1'b0, cell_e[0].fire_time} + (TimeW + 1)'(cell_e[0].period);

  always_comb begin
    ctrl.ins = busy_r || (accept && (in_operation == OP_REGISTER) && !is_full);
    ctrl.shl = accept && (in_operation == OP_POP) && !is_empty;
    if (busy_r) begin
      new_entry = pend_r;
      new_slot  = pend_slot_r;
    end else begin
      new_entry.fire_time = TimeW'(in_period);
      new_entry.id        = in_query_id;
      new_entry.period    = in_period;
      new_slot            = count_r[SLOTW-1:0];
    end
  end

  always_comb begin
    count_nxt      = count_r;
    busy_nxt       = 1'b0;
    pend_nxt       = pend_r;
    pend_slot_nxt  = pend_slot_r;
    out_valid_nxt  = accept;
    out_id_nxt     = '0;
    out_time_nxt   = '0;
    out_status_nxt = ST_OK;
    if (accept) begin
      if (in_operation == OP_REGISTER) begin
        if (is_full) begin
          out_status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNTW'(1);
        end
      end else if (is_empty) begin
        out_status_nxt = ST_EMPTY;
      end else begin
        busy_nxt      = 1'b1;
        pend_nxt      = cell_e[0];
        pend_slot_nxt = cell_s[0];
        pend_nxt.fire_time = next_sum[TimeW] ? '1 : next_sum[TimeW-1:0];
        out_id_nxt     = cell_e[0].id;
        out_time_nxt   = cell_e[0].fire_time;
        out_status_nxt = next_sum[TimeW] ? ST_SAT : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r       <= pend_nxt;
    pend_slot_r  <= pend_slot_nxt;
    out_id_r     <= out_id_nxt;
    out_time_r   <= out_time_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_fired_id  = out_id_r;
  assign out_fire_time = out_time_r;
  assign out_status    = out_status_r;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    localparam logic [CNTW-1:0] Idx = CNTW'(i);
    localparam int Lft = (i > 0) ? i - 1 : 0;
    localparam int Rgt = (i < MAX_ENTRIES - 1) ? i + 1 : i;

    logic cell_valid;
    logic left_lt;

    assign cell_valid = (Idx < occupancy);
    assign left_lt    = (i > 0) ? cell_lt[Lft] : 1'b0;

    pqs_cell #(
      .SLOTW(SLOTW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid      (cell_valid),
      .new_entry  (new_entry),
      .new_slot   (new_slot),
      .left_lt    (left_lt),
      .left_entry (cell_e[Lft]),
      .left_slot  (cell_s[Lft]),
      .right_entry(cell_e[Rgt]),
      .right_slot (cell_s[Rgt]),
      .new_lt     (cell_lt[i]),
      .entry      (cell_e[i]),
      .slot       (cell_s[i])
    );
  end

  // The reinsert phase of a pop lasts exactly one cycle.
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> !busy_r)
    else $error("reinsert phase lasted more than one cycle");

  // A reinsert needs the popped entry to still be counted.
  a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (count_r != '0))
    else $error("reinsert with empty table");

  // Every result follows a request taken in the cycle before.
  a_result_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept))
    else $error("result without request");

  // The fill count never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MaxCnt)
    else $error("entry count out of range");

  // A full report only comes with a full table.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> is_full)
    else $error("full status with room left");

endmodule

FILE: tb/periodic_query_scheduler_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for periodic_query_scheduler: a table of directed requests,
// then random requests and a fill to full, each checked against a typed value or a model.
// Depends on pqs_pkg and the scheduler RTL.
module periodic_query_scheduler_test;
  import pqs_pkg::*;

  localparam int Slots = 64;
  localparam int CycleLimit = 200_000;
  localparam int RandomRequests = 1050;

  typedef struct packed {
    logic [15:0] fired_id;
    logic [31:0] fire_time;
    logic [1:0]  status;
  } fire_result_t;

  typedef struct packed {
    logic        op;
    logic [15:0] qid;
    logic [15:0] per;
    int unsigned reps;
    logic        typed;
    logic [15:0] x_id;
    logic [31:0] x_time;
    logic [1:0]  x_status;
  } script_row_t;

  // A lone period-65535 entry is popped three times, stepping by its full period each time,
  // and then stays far behind the short-period entries registered after it.
  localparam script_row_t SCRIPT [25] = '{
    '{OP_POP,      16'h0000, 16'h0000, 1,     1'b1, 16'h0000, 32'h0000_0000, ST_EMPTY},
    '{OP_POP,      16'hFFFF, 16'hFFFF, 1,     1'b1, 16'h0000, 32'h0000_0000, ST_EMPTY},
    '{OP_REGISTER, 16'hFFFF, 16'hFFFF, 1,     1'b1, 16'h0000, 32'h0000_0000, ST_OK},
    '{OP_POP,      16'h0000, 16'h0000, 1,     1'b1, 16'hFFFF, 32'h0000_FFFF, ST_OK},
    '{OP_POP,      16'h0000, 16'h0000, 1,     1'b1, 16'hFFFF, 32'h0001_FFFE, ST_OK},
    '{OP_POP,      16'h1234, 16'h4321, 1,     1'b1, 16'hFFFF, 32'h0002_FFFD, ST_OK},
    '{OP_REGISTER, 16'h0000, 16'h0001, 1,     1'b1, 16'h0000, 32'h0000_0000, ST_OK},
    '{OP_REGISTER, 16'h8000, 16'h0001, 1,     1'b1, 16'h0000, 32'h0000_0000, ST_OK},
    '{OP_REGISTER, 16'h0001, 16'h0002, 1,     1'b1, 16'h0000, 32'h0000_0000, ST_OK},
    '{OP_REGISTER, 16'h7FFF, 16'h8000, 1,     1'b1, 16'h0000, 32'h0000_0000, ST_OK},
    '{OP_POP,      16'h0000, 16'h0000, 1,     1'b1, 16'h0000, 32'h0000_0001, ST_OK},
    '{OP_POP,      16'h0000, 16'h0000, 1,     1'b1, 16'h8000, 32'h0000_0001, ST_OK},
    '{OP_POP,      16'h0000, 16'h0000, 1,     1'b1, 16'h0000, 32'h0000_0002, ST_OK},
    '{OP_POP,      16'h0000, 16'h0000, 1,     1'b1, 16'h0001, 32'h0000_0002, ST_OK},
    '{OP_REGISTER, 16'h0001, 16'h0003, 1,     1'b0, 16'h0000, 32'h0000_0000, ST_OK},
    '{OP_REGISTER, 16'h0001, 16'h0003, 1,     1'b0, 16'h0000, 32'h0000_0000, ST_OK},
    '{OP_POP,      16'h0000, 16'h0000, 1,     1'b0, 16'h0000, 32'h0000_0000, ST_OK},
    '{OP_POP,      16'hFFFF, 16'hFFFF, 1,     1'b0, 16'h0000, 32'h0000_0000, ST_OK},
    '{OP_POP,      16'h0000, 16'h0000, 1,     1'b0, 16'h0000, 32'h0000_0000, ST_OK},
    '{OP_POP,      16'h0000, 16'h0000, 1,     1'b0, 16'h0000, 32'h0000_0000, ST_OK},
    '{OP_POP,      16'h0000, 16'h0000, 1,     1'b0, 16'h0000, 32'h0000_0000, ST_OK},
    '{OP_REGISTER, 16'h5555, 16'hAAAA, 1,     1'b0, 16'h0000, 32'h0000_0000, ST_OK},
    '{OP_REGISTER, 16'hAAAA, 16'h5555, 1,     1'b0, 16'h0000, 32'h0000_0000, ST_OK},
    '{OP_POP,      16'h0000, 16'h0000, 1,     1'b0, 16'h0000, 32'h0000_0000, ST_OK},
    '{OP_POP,      16'h0000, 16'h0000, 1,     1'b0, 16'h0000, 32'h0000_0000, ST_OK}
  };

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_operation;
  logic [15:0] in_query_id;
  logic [15:0] in_period;
  logic        out_valid;
  logic [15:0] out_fired_id;
  logic [31:0] out_fire_time;
  logic [1:0]  out_status;

  // Model of the scheduler table, updated when a request is taken.
  logic [31:0] tbl_time [Slots];
  logic [15:0] tbl_id [Slots];
  logic [15:0] tbl_period [Slots];
  int          tbl_count;

  fire_result_t expected_results [$];
  int          errors = 0;
  int unsigned cycle_count = 0;

  periodic_query_scheduler #(
    .MAX_ENTRIES(Slots)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_query_id  (in_query_id),
    .in_period    (in_period),
    .out_valid    (out_valid),
    .out_fired_id (out_fired_id),
    .out_fire_time(out_fire_time),
    .out_status   (out_status)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic fire_result_t schedule_step(input logic op, input logic [15:0] qid,
                                                 input logic [15:0] per);
    fire_result_t res;
    int win;
    logic [32:0] next_time;
    res = '0;
    if (op == OP_REGISTER) begin
      if (tbl_count >= Slots) begin
        res.status = ST_FULL;
      end else begin
        tbl_time[tbl_count] = {16'h0000, per};
        tbl_id[tbl_count] = qid;
        tbl_period[tbl_count] = per;
        tbl_count++;
        res.status = ST_OK;
      end
    end else if (tbl_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      win = 0;
      for (int i = 1; i < tbl_count; i++) begin
        if (tbl_time[i] < tbl_time[win] ||
            (tbl_time[i] == tbl_time[win] && tbl_id[i] < tbl_id[win]))
          win = i;
      end
      res.fired_id = tbl_id[win];
      res.fire_time = tbl_time[win];
      res.status = ST_OK;
      next_time = {1'b0, tbl_time[win]} + {17'h0_0000, tbl_period[win]};
      if (next_time[32]) begin
        next_time = 33'h0_FFFF_FFFF;
        res.status = ST_SAT;
      end
      tbl_time[win] = next_time[31:0];
    end
    return res;
  endfunction

  // Called and returns at a falling edge. Start is lowered only when a gap is asked for,
  // so it never gets two assignments in one time step.
  task automatic send_request(input logic op, input logic [15:0] qid, input logic [15:0] per,
                              input int gap, input logic typed, input fire_result_t typed_res);
    fire_result_t res;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_query_id <= qid;
    in_period <= per;
    do @(posedge clk); while (busy);
    res = schedule_step(op, qid, per);
    expected_results = {expected_results, (typed ? typed_res : res)};
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    do @(negedge clk); while (expected_results.size() != 0);
  endtask

  always @(posedge clk) begin
    fire_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: id %0h time %0h status %0d",
               out_fired_id, out_fire_time, out_status);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_fired_id !== want.fired_id) begin
          $error("fired_id: expected %0h, got %0h", want.fired_id, out_fired_id);
          errors++;
        end
        if (out_fire_time !== want.fire_time) begin
          $error("fire_time: expected %0h, got %0h", want.fire_time, out_fire_time);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    script_row_t row;
    logic op;
    logic [15:0] qid;
    logic [15:0] per;
    int gap;
    logic quiet;
    fire_result_t typed_res;

    tbl_count = 0;
    quiet = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_REGISTER;
    in_query_id = '0;
    in_period = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (SCRIPT[r]) begin
      row = SCRIPT[r];
      typed_res = '{fired_id: row.x_id, fire_time: row.x_time, status: row.x_status};
      for (int unsigned k = 0; k < row.reps; k++) begin
        gap = (row.reps > 1) ? 0 : $urandom_range(0, 13);
        send_request(row.op, row.qid, row.per, gap, row.typed, typed_res);
      end
    end
    wait_for_results();

    // Registers are held back at 63 entries so a zero-period entry still fits at the end.
    for (int n = 0; n < RandomRequests; n++) begin
      if (n % 40 == 0)
        quiet = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 49) == 0)
        wait_for_results();
      gap = quiet ? 0 : $urandom_range(0, 13);
      if (tbl_count < Slots - 1 && $urandom_range(0, 99) < 35) begin
        op = OP_REGISTER;
        if (tbl_count > 0 && $urandom_range(0, 19) == 0)
          qid = tbl_id[$urandom_range(0, tbl_count - 1)];
        else
          qid = 16'($urandom);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: per = 16'($urandom_range(1, 16));
          6, 7, 8:          per = 16'($urandom_range(1, 65535));
          default:          per = 16'($urandom_range(65000, 65535));
        endcase
      end else begin
        op = OP_POP;
        qid = 16'($urandom);
        per = 16'($urandom);
      end
      send_request(op, qid, per, gap, 1'b0, '0);
    end
    wait_for_results();

    // A zero-period entry fires at time zero forever, so it only comes at the very end.
    send_request(OP_REGISTER, 16'h1234, 16'h0000, $urandom_range(0, 13), 1'b0, '0);
    repeat (2) send_request(OP_POP, 16'($urandom), 16'($urandom), $urandom_range(0, 13),
                            1'b0, '0);
    while (tbl_count < Slots)
      send_request(OP_REGISTER, 16'($urandom), 16'($urandom_range(1, 65535)),
                   $urandom_range(0, 13), 1'b0, '0);
    repeat (4) send_request(OP_REGISTER, 16'($urandom), 16'($urandom_range(1, 65535)),
                            $urandom_range(0, 13), 1'b0, '0);
    repeat (2) send_request(OP_POP, 16'($urandom), 16'($urandom), $urandom_range(0, 13),
                            1'b0, '0);

    wait_for_results();
    repeat (4) @(negedge clk);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
